[src/nmea_pkg.sv]
// Shared constants for the NMEA RMC position extractor.
`timescale 1ns / 1ps

package nmea_pkg;

    localparam int FIELD_MAX_DEF = 16;

    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_N      = 8'h4E;
    localparam logic [7:0] CHAR_P      = 8'h50;
    localparam logic [7:0] CHAR_R      = 8'h52;
    localparam logic [7:0] CHAR_M      = 8'h4D;
    localparam logic [7:0] CHAR_C      = 8'h43;

    // Header progress codes.
    localparam logic [2:0] HP_WAIT = 3'd0;
    localparam logic [2:0] HP_DONE = 3'd6;
    localparam logic [2:0] HP_BAD  = 3'd7;

    localparam logic [2:0] COMMAS_ALL = 3'd7;
    localparam logic [2:0] FLD_LAT    = 3'd3;
    localparam logic [2:0] FLD_NS     = 3'd4;
    localparam logic [2:0] FLD_LON    = 3'd5;
    localparam logic [2:0] FLD_EW     = 3'd6;

endpackage

[src/nmea_field_mem.sv]
// Synchronous field memory holding the latitude and longitude characters.
`timescale 1ns / 1ps

module nmea_field_mem
    import nmea_pkg::*;
#(
    parameter int FIELD_MAX = FIELD_MAX_DEF
)
(
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic                         wr_sel,
    input  logic [$clog2(FIELD_MAX)-1:0] wr_idx,
    input  logic [7:0]                   wr_data,
    input  logic                         rd_en,
    input  logic                         rd_sel,
    input  logic [$clog2(FIELD_MAX)-1:0] rd_idx,
    output logic [7:0]                   rd_data
);

    localparam int IDX_W     = $clog2(FIELD_MAX);
    localparam int MEM_DEPTH = 2 ** (IDX_W + 1);

    logic [7:0] mem [MEM_DEPTH];
    logic [7:0] rd_data_reg;

    // The select bit picks the latitude half or the longitude half.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[{wr_sel, wr_idx}] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[{rd_sel, rd_idx}];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/nmea_rmc_position_extractor.sv]
// Top level of the NMEA RMC position extractor: sentence parser and output sequencer.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid, in_ready, rx_byte) takes one received character per item.
// The output channel (out_valid, out_ready, out_char, last) gives the reformatted line:
// N/S, the latitude text, E/W, the longitude text and a newline, with last set on the
// newline. A line is produced only when a newline ends a $GNRMC or $GPRMC sentence in
// which seven commas were seen; otherwise a newline produces nothing.
// Input flow: every character other than a qualifying newline leaves the input open.
// A qualifying newline holds the input while the line is sent, since each stored
// character is first read from the field memory and then its registered data is moved
// to the output; the sequencer waits whenever the output register is not free.
// After the newline is accepted, the first item is loaded once the output is free.
// Results sit in an output register, so the input is taken again as soon as the last
// item of a line is loaded, even while the receiver has not yet taken it.
// When the receiver stalls, the output register holds and the sequencer waits.
// Reset clears the sentence state and out_valid, not out_char or last; the field
// memory is not cleared, as only entries below the captured lengths are ever read.

module nmea_rmc_position_extractor
    import nmea_pkg::*;
#(
    parameter int FIELD_MAX = FIELD_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       last
);

    localparam int IDX_W = $clog2(FIELD_MAX);
    localparam int LEN_W = $clog2(FIELD_MAX + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(FIELD_MAX);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NS,
        ST_LAT_RD,
        ST_LAT_WT,
        ST_EW,
        ST_LON_RD,
        ST_LON_WT,
        ST_NL
    } state_t;

    state_t           state_reg, state_next;
    logic [2:0]       hp_reg, hp_next;
    logic             hok_reg, hok_next;
    logic [2:0]       comma_reg, comma_next;
    logic [LEN_W-1:0] lat_len_reg, lat_len_next;
    logic [LEN_W-1:0] lon_len_reg, lon_len_next;
    logic [7:0]       ns_reg, ns_next;
    logic [7:0]       ew_reg, ew_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic             last_reg, last_next;

    logic             slot_free;
    logic             wr_en;
    logic             wr_sel;
    logic [IDX_W-1:0] wr_idx;
    logic             rd_en;
    logic             rd_sel;
    logic [7:0]       rd_data;
    logic             idx_at_end_lat;
    logic             idx_at_end_lon;

    function automatic logic hdr_char_ok(input logic [2:0] pos, input logic [7:0] c);
        logic ok;
        case (pos)
            3'd1:    ok = (c == CHAR_G);
            3'd2:    ok = (c == CHAR_N) || (c == CHAR_P);
            3'd3:    ok = (c == CHAR_R);
            3'd4:    ok = (c == CHAR_M);
            3'd5:    ok = (c == CHAR_C);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    nmea_field_mem #(
        .FIELD_MAX (FIELD_MAX)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_sel  (wr_sel),
        .wr_idx  (wr_idx),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_sel  (rd_sel),
        .rd_idx  (idx_reg),
        .rd_data (rd_data)
    );

    assign slot_free      = !out_valid_reg || out_ready;
    assign in_ready       = (state_reg == ST_IDLE);
    assign idx_at_end_lat = (LEN_W'(idx_reg) + LEN_W'(1)) == lat_len_reg;
    assign idx_at_end_lon = (LEN_W'(idx_reg) + LEN_W'(1)) == lon_len_reg;

    always_comb
    begin
        state_next    = state_reg;
        hp_next       = hp_reg;
        hok_next      = hok_reg;
        comma_next    = comma_reg;
        lat_len_next  = lat_len_reg;
        lon_len_next  = lon_len_reg;
        ns_next       = ns_reg;
        ew_next       = ew_reg;
        idx_next      = idx_reg;
        out_char_next = out_char_reg;
        last_next     = last_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        wr_en         = 1'b0;
        wr_sel        = 1'b0;
        wr_idx        = lat_len_reg[IDX_W-1:0];
        rd_en         = 1'b0;
        rd_sel        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (rx_byte == CHAR_NL)
                    begin
                        hp_next    = HP_WAIT;
                        hok_next   = 1'b0;
                        comma_next = 3'd0;
                        if (hok_reg && comma_reg == COMMAS_ALL)
                        begin
                            // Captured fields stay until the line has been sent.
                            state_next = ST_NS;
                        end
                        else
                        begin
                            lat_len_next = '0;
                            lon_len_next = '0;
                            ns_next      = 8'd0;
                            ew_next      = 8'd0;
                        end
                    end
                    else if (rx_byte == CHAR_DOLLAR)
                    begin
                        hp_next      = 3'd1;
                        hok_next     = 1'b0;
                        comma_next   = 3'd0;
                        lat_len_next = '0;
                        lon_len_next = '0;
                        ns_next      = 8'd0;
                        ew_next      = 8'd0;
                    end
                    else if (hp_reg == HP_WAIT || hp_reg == HP_BAD)
                    begin
                        hp_next = hp_reg;
                    end
                    else if (hp_reg != HP_DONE)
                    begin
                        if (hdr_char_ok(hp_reg, rx_byte))
                        begin
                            hp_next = hp_reg + 3'd1;
                            if (hp_reg == 3'd5)
                            begin
                                hok_next = 1'b1;
                            end
                        end
                        else
                        begin
                            hp_next = HP_BAD;
                        end
                    end
                    else if (comma_reg != COMMAS_ALL)
                    begin
                        if (rx_byte == CHAR_COMMA)
                        begin
                            comma_next = comma_reg + 3'd1;
                        end
                        else
                        begin
                            case (comma_reg)
                                FLD_LAT:
                                begin
                                    if (lat_len_reg < LEN_MAX)
                                    begin
                                        wr_en        = 1'b1;
                                        wr_sel       = 1'b0;
                                        wr_idx       = lat_len_reg[IDX_W-1:0];
                                        lat_len_next = lat_len_reg + LEN_W'(1);
                                    end
                                end
                                FLD_NS:
                                begin
                                    if (ns_reg == 8'd0)
                                    begin
                                        ns_next = rx_byte;
                                    end
                                end
                                FLD_LON:
                                begin
                                    if (lon_len_reg < LEN_MAX)
                                    begin
                                        wr_en        = 1'b1;
                                        wr_sel       = 1'b1;
                                        wr_idx       = lon_len_reg[IDX_W-1:0];
                                        lon_len_next = lon_len_reg + LEN_W'(1);
                                    end
                                end
                                FLD_EW:
                                begin
                                    if (ew_reg == 8'd0)
                                    begin
                                        ew_next = rx_byte;
                                    end
                                end
                                default:
                                begin
                                    ew_next = ew_reg;
                                end
                            endcase
                        end
                    end
                end
            end

            ST_NS:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ns_reg;
                    last_next      = 1'b0;
                    idx_next       = '0;
                    state_next     = (lat_len_reg == '0) ? ST_EW : ST_LAT_RD;
                end
            end

            ST_LAT_RD:
            begin
                rd_en      = 1'b1;
                rd_sel     = 1'b0;
                state_next = ST_LAT_WT;
            end

            ST_LAT_WT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = rd_data;
                    last_next      = 1'b0;
                    if (idx_at_end_lat)
                    begin
                        idx_next   = '0;
                        state_next = ST_EW;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_LAT_RD;
                    end
                end
            end

            ST_EW:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ew_reg;
                    last_next      = 1'b0;
                    idx_next       = '0;
                    state_next     = (lon_len_reg == '0) ? ST_NL : ST_LON_RD;
                end
            end

            ST_LON_RD:
            begin
                rd_en      = 1'b1;
                rd_sel     = 1'b1;
                state_next = ST_LON_WT;
            end

            ST_LON_WT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = rd_data;
                    last_next      = 1'b0;
                    if (idx_at_end_lon)
                    begin
                        idx_next   = '0;
                        state_next = ST_NL;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_LON_RD;
                    end
                end
            end

            ST_NL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_NL;
                    last_next      = 1'b1;
                    lat_len_next   = '0;
                    lon_len_next   = '0;
                    ns_next        = 8'd0;
                    ew_next        = 8'd0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hp_reg        <= HP_WAIT;
            hok_reg       <= 1'b0;
            comma_reg     <= 3'd0;
            lat_len_reg   <= '0;
            lon_len_reg   <= '0;
            ns_reg        <= 8'd0;
            ew_reg        <= 8'd0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hp_reg        <= hp_next;
            hok_reg       <= hok_next;
            comma_reg     <= comma_next;
            lat_len_reg   <= lat_len_next;
            lon_len_reg   <= lon_len_next;
            ns_reg        <= ns_next;
            ew_reg        <= ew_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

endmodule

[src/nmea_checker.sv]
// Port-level assertions for the NMEA RMC position extractor, bound to the top level.
`timescale 1ns / 1ps

module nmea_checker
    import nmea_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] rx_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       last
);

    // The item that ends a line is always a newline.
    a_last_is_nl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> out_char == CHAR_NL)
        else $error("last set on a character other than newline");

    // A stalled output item holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last))
        else $error("output item changed while stalled");

    // Only a newline can stop the block from taking the next character.
    a_non_nl_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && rx_byte != CHAR_NL |=> in_ready)
        else $error("input stalled after an ordinary character");

    // A new output item is produced only while the input is held off.
    a_emit_during_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (!$past(out_valid) || $past(out_ready)) |-> !$past(in_ready))
        else $error("output item produced while input was open");

endmodule

bind nmea_rmc_position_extractor nmea_checker u_nmea_checker (.*);

[tb/sv/nmea_rmc_position_extractor_tb.sv]
// Testbench for the NMEA RMC position extractor with a self-checking line predictor.
`timescale 1ns / 1ps

module nmea_rmc_position_extractor_tb;
    import nmea_pkg::*;

    localparam int RANDOM_BYTES = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed
    {
        logic [7:0] ch;
        logic       fin;
    } line_char_t;

    // Tracks the sentence state and queues the characters each newline must produce.
    class position_line_board;
        logic [2:0] hdr_pos;
        logic       hdr_ok;
        logic [2:0] commas;
        logic [7:0] lat_text [FIELD_MAX_DEF];
        logic [7:0] lon_text [FIELD_MAX_DEF];
        int         lat_n;
        int         lon_n;
        logic [7:0] ns_c;
        logic [7:0] ew_c;
        line_char_t pending [$];
        int         errors;

        function new();
            errors = 0;
            clear_sentence();
        endfunction

        function void clear_sentence();
            hdr_pos = HP_WAIT;
            hdr_ok  = 1'b0;
            commas  = 3'd0;
            lat_n   = 0;
            lon_n   = 0;
            ns_c    = 8'h00;
            ew_c    = 8'h00;
        endfunction

        function void push_char(logic [7:0] c, logic fin);
            line_char_t e;
            e.ch  = c;
            e.fin = fin;
            pending.push_back(e);
        endfunction

        function void note_byte(logic [7:0] c);
            logic fits;
            if (c == CHAR_NL)
            begin
                if (hdr_ok && commas == COMMAS_ALL)
                begin
                    push_char(ns_c, 1'b0);
                    for (int i = 0; i < lat_n; i++)
                        push_char(lat_text[i], 1'b0);
                    push_char(ew_c, 1'b0);
                    for (int i = 0; i < lon_n; i++)
                        push_char(lon_text[i], 1'b0);
                    push_char(CHAR_NL, 1'b1);
                end
                clear_sentence();
                return;
            end
            if (c == CHAR_DOLLAR)
            begin
                clear_sentence();
                hdr_pos = 3'd1;
                return;
            end
            if (hdr_pos == HP_WAIT || hdr_pos == HP_BAD)
                return;
            if (hdr_pos != HP_DONE)
            begin
                case (hdr_pos)
                    3'd1:    fits = (c == CHAR_G);
                    3'd2:    fits = (c == CHAR_N) || (c == CHAR_P);
                    3'd3:    fits = (c == CHAR_R);
                    3'd4:    fits = (c == CHAR_M);
                    default: fits = (c == CHAR_C);
                endcase
                if (fits)
                begin
                    hdr_pos = hdr_pos + 3'd1;
                    if (hdr_pos == HP_DONE)
                        hdr_ok = 1'b1;
                end
                else
                    hdr_pos = HP_BAD;
                return;
            end
            if (commas == COMMAS_ALL)
                return;
            if (c == CHAR_COMMA)
            begin
                commas = commas + 3'd1;
                return;
            end
            case (commas)
                FLD_LAT:
                    if (lat_n < FIELD_MAX_DEF)
                    begin
                        lat_text[lat_n] = c;
                        lat_n++;
                    end
                FLD_NS:
                    if (ns_c == 8'h00)
                        ns_c = c;
                FLD_LON:
                    if (lon_n < FIELD_MAX_DEF)
                    begin
                        lon_text[lon_n] = c;
                        lon_n++;
                    end
                FLD_EW:
                    if (ew_c == 8'h00)
                        ew_c = c;
                default: ;
            endcase
        endfunction

        function void check_char(logic [7:0] c, logic fin);
            line_char_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected item out_char=%02h last=%0b", $time, c, fin);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (c !== e.ch)
            begin
                $display("%0t: out_char expected %02h, got %02h", $time, e.ch, c);
                errors++;
            end
            if (fin !== e.fin)
            begin
                $display("%0t: last expected %0b, got %0b", $time, e.fin, fin);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_char;
    logic       last;

    position_line_board board;
    bit gaps_on = 1'b1;
    int bytes_sent = 0;
    int quiet_cycles = 0;

    nmea_rmc_position_extractor u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Output checking, receiver stalls and the no-progress watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_char(out_char, last);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
        out_ready <= gaps_on ? ($urandom_range(0, 99) >= 10) : 1'b1;
    end

    task automatic send_byte(input logic [7:0] b);
        while (gaps_on && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Holds the input off until every queued line character has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] field_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CHAR_COMMA || b == CHAR_NL || b == CHAR_DOLLAR);
        return b;
    endfunction

    // Sends '$' and the five header characters; bad_at names a position to corrupt.
    task automatic send_header(input int bad_at);
        logic [7:0] good;
        logic [7:0] b;
        send_byte(CHAR_DOLLAR);
        for (int p = 1; p <= 5; p++)
        begin
            case (p)
                1:       good = CHAR_G;
                2:       good = $urandom_range(0, 1) ? CHAR_N : CHAR_P;
                3:       good = CHAR_R;
                4:       good = CHAR_M;
                default: good = CHAR_C;
            endcase
            b = good;
            if (p == bad_at)
            begin
                do
                    b = field_byte();
                while (b == good || (p == 2 && (b == CHAR_N || b == CHAR_P)));
            end
            send_byte(b);
        end
    endtask

    task automatic send_fields(input int n_commas);
        int len;
        logic [7:0] b;
        for (int f = 1; f <= n_commas; f++)
        begin
            send_byte(CHAR_COMMA);
            if (f == FLD_LAT || f == FLD_LON)
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 6);
            else if (f == FLD_NS || f == FLD_EW)
                len = $urandom_range(0, 2);
            else if (f < COMMAS_ALL)
                len = $urandom_range(0, 3);
            else
                len = 0;
            for (int i = 0; i < len; i++)
            begin
                b = field_byte();
                if ((f == FLD_NS || f == FLD_EW) && $urandom_range(0, 7) == 0)
                    b = 8'h00;
                send_byte(b);
            end
        end
    endtask

    task automatic send_random_sentence();
        int kind;
        int n_commas;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            repeat ($urandom_range(1, 12))
                send_byte(8'($urandom_range(0, 255)));
            send_byte(CHAR_NL);
            return;
        end
        // A sentence cut short by a fresh '$'.
        if (kind < 14)
        begin
            send_header(0);
            send_fields($urandom_range(0, 5));
        end
        send_header((kind >= 14 && kind < 24) ? $urandom_range(1, 5) : 0);
        n_commas = (kind >= 24 && kind < 32) ? $urandom_range(0, 6) : COMMAS_ALL;
        send_fields(n_commas);
        if (n_commas == COMMAS_ALL)
        begin
            repeat ($urandom_range(0, 5))
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CHAR_NL || b == CHAR_DOLLAR);
                send_byte(b);
            end
        end
        send_byte(CHAR_NL);
    endtask

    initial
    begin
        int start;
        int s;
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bytes before any '$', then a bare newline.
        send_text("xyz");
        send_byte(CHAR_NL);
        // Latitude overflows the store; longitude fills it exactly.
        send_text("$GPRMC,123519,A,48070380000000000123,N,0113100000000000,E,022.4,*6A");
        send_byte(8'h0D);
        send_byte(CHAR_NL);
        // All fields empty: both hemispheres come out as zero bytes.
        send_text("$GNRMC,,,,,,,");
        send_byte(CHAR_NL);
        // A zero byte in a hemisphere field is replaced by the next character.
        send_text("$GNRMC,1,2,");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text(",");
        send_byte(8'h00);
        send_text("SX,");
        send_byte(8'h7F);
        send_byte(8'h80);
        send_text(",WE,");
        send_byte(CHAR_NL);
        // Header mismatch, a restart in mid sentence, and too few commas.
        send_text("$GPRMB,1,2,3,4,5,6,7");
        send_byte(CHAR_NL);
        send_text("$GPRMC,1,2,$GNRMC,,,5,S,6,W,x");
        send_byte(CHAR_NL);
        send_text("$GPRMC,1,2,3,4,5,6");
        send_byte(CHAR_NL);
        wait_drained();

        start = bytes_sent;
        s = 0;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            gaps_on = !(s >= 1 && s < 3);
            if (s == 3)
                wait_drained();
            send_random_sentence();
            s++;
        end
        gaps_on = 1'b1;

        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
